>>> src/aes128_block_encrypt_core_defines.svh
// assertion macros for the aes128 encrypt core
`ifndef AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/aes_pkg.sv
package aes_pkg;
   localparam int NumRounds = 10;
   localparam int NumStages = NumRounds + 1;
   localparam logic [1:0] CsrKeyHigh = 2'd0;
   localparam logic [1:0] CsrKeyLow = 2'd1;

   typedef logic [127:0] block_type;
   typedef logic [7:0] byte_type;

   function automatic byte_type sbox(input byte_type b);
      byte_type t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[b];
   endfunction

   function automatic byte_type xtime(input byte_type b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte k of the block sits in bits 127-8k down to 120-8k
   function automatic byte_type get_byte(input block_type s, input int k);
      return s[127 - 8 * k -: 8];
   endfunction

   function automatic block_type round_fn(input block_type s, input block_type rk,
                                          input logic last);
      block_type o;
      byte_type t [16];
      byte_type a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            t[k + 4 * c] = sbox(get_byte(s, k + 4 * ((c + k) % 4)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
         if (last) begin
            o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
         end else begin
            o[127 - 32 * c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                     a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                     a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                     xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
         end
      end
      return o ^ rk;
   endfunction

   function automatic block_type next_key(input block_type k, input byte_type rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction
endpackage

>>> src/aes128_block_encrypt_core.sv
// aes-128 ecb encrypt, eleven register stages (initial key add plus ten rounds)
// each accepted item moves through every stage in order; rsp_tvalid is the tail valid bit
// throughput: one item per cycle; the whole pipe stalls while a result waits on rsp_tready
// key writes ripple to all round keys; user sends no item till then, block does not check
// reset: synchronous active high, clears valid bits and sets the key to zero
module aes128_block_encrypt_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [127:0] req_tdata,   // plain_low, plain_high
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [127:0] rsp_tdata,   // cipher_low, cipher_high
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_wdata
);
   import aes_pkg::*;

   block_type round_key [NumStages];
   block_type cipher;

   aes_key_sched u_key (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .round_key(round_key)
   );

   aes_round_pipe u_pipe (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data({req_tdata[63:0], req_tdata[127:64]}), .round_key(round_key),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(cipher)
   );

   // block is {high, low}; tdata holds high field in low bits
   assign rsp_tdata = {cipher[63:0], cipher[127:64]};
endmodule

>>> src/aes_key_sched.sv
module aes_key_sched (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_wdata,
   output aes_pkg::block_type round_key [aes_pkg::NumStages]
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   block_type keys_ff [NumStages];
   block_type keys_in [NumStages];
   byte_type rc [NumStages];

   // keys are recomputed one round a cycle; the user must change config only while idle, the block does not enforce it
   always_comb begin
      rc[0] = 8'h01;
      for (int i = 1; i < NumStages; i++) rc[i] = xtime(rc[i - 1]);
      keys_in[0] = {key_high_ff, key_low_ff};
      for (int i = 1; i < NumStages; i++) keys_in[i] = next_key(keys_ff[i - 1], rc[i - 1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == CsrKeyHigh) key_high_ff <= csr_wdata;
         if (csr_index == CsrKeyLow) key_low_ff <= csr_wdata;
      end
      keys_ff <= keys_in;
   end

   assign round_key = keys_ff;
endmodule

>>> src/aes_round_pipe.sv
`include "aes128_block_encrypt_core_defines.svh"
module aes_round_pipe (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  aes_pkg::block_type in_data,
   input  aes_pkg::block_type round_key [aes_pkg::NumStages],
   output logic out_valid,
   input  logic out_ready,
   output aes_pkg::block_type out_data
);
   import aes_pkg::*;

   logic valid_ff [NumStages];
   block_type data_ff [NumStages];
   logic adv;

   // whole pipe advances together; a bubble at the tail still lets it move
   assign adv = out_ready || !valid_ff[NumStages - 1];
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStages; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < NumStages; i++) valid_ff[i] <= valid_ff[i - 1];
      end
      if (adv) begin
         data_ff[0] <= in_data ^ round_key[0];
         for (int i = 1; i < NumStages; i++) begin
            data_ff[i] <= round_fn(data_ff[i - 1], round_key[i], i == NumRounds);
         end
      end
   end

   assign out_valid = valid_ff[NumStages - 1];
   assign out_data = data_ff[NumStages - 1];

   `AES_ASSERT_NEXT(a_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(out_data), "result lost under stall")
   `AES_ASSERT_NEXT(a_move, clock, reset, in_valid && in_ready, valid_ff[0], "accepted item not captured")
   `AES_ASSERT_IMPL(a_ready, clock, reset, !out_valid, in_ready, "stall without full tail")
endmodule

>>> dv/aes_encrypt_checker.sv
module aes_encrypt_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [127:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_wdata,
   output int error_count,
   output int cipher_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import aes_pkg::*;

   logic [63:0] key_hi, key_lo;
   logic [127:0] cipher_queue[$];
   logic [7:0] sub_lut [256];

   function automatic logic [7:0] dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // gf(2^8) multiply used to find the inverse; sub_lut is 0x63 xor the affine-transformed inverse, built from scratch
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = dbl(a);
      end
      return p;
   endfunction

   initial begin
      logic [7:0] inv, x;
      for (int v = 0; v < 256; v++) begin
         inv = 8'h00;
         for (int w = 1; w < 256; w++)
            if (gmul(v[7:0], w[7:0]) == 8'h01) inv = w[7:0];
         x = inv;
         for (int i = 0; i < 8; i++)
            x[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
                   ^ inv[(i + 7) % 8];
         sub_lut[v] = x ^ 8'h63;
      end
   end

   function automatic logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] pt);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] f, rc, a0, a1, a2, a3;
      logic [127:0] o;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127 - 8 * i -: 8];
         s[i] = pt[127 - 8 * i -: 8] ^ rk[i];
      end
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
         if (i % 16 == 0) begin
            f = w[0];
            w[0] = sub_lut[w[1]] ^ rc;
            w[1] = sub_lut[w[2]];
            w[2] = sub_lut[w[3]];
            w[3] = sub_lut[f];
            rc = dbl(rc);
         end
         for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
      end
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++) t[k + 4 * c] = sub_lut[s[k + 4 * ((c + k) % 4)]];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            if (r < 10) begin
               s[4 * c]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
               s[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
               s[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
               s[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
            end else begin
               s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
            end
         end
         for (int k = 0; k < 16; k++) s[k] ^= rk[16 * r + k];
      end
      for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
      return o;
   endfunction

   assign cipher_pending = cipher_queue.size();

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         key_hi <= '0;
         key_lo <= '0;
         error_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CsrKeyHigh) key_hi <= csr_wdata;
            else if (csr_index == CsrKeyLow) key_lo <= csr_wdata;
         end
         if (req_tvalid && req_tready)
            cipher_queue.push_back(encrypt({key_hi, key_lo},
                                           {req_tdata[63:0], req_tdata[127:64]}));
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_queue.size() == 0) begin
               if (error_count < 10) $display("unexpected cipher item %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = cipher_queue.pop_front();
               if (rsp_tdata[63:0] !== want[127:64] || rsp_tdata[127:64] !== want[63:0]) begin
                  if (error_count < 10)
                     $display("cipher mismatch: high exp %h got %h, low exp %h got %h",
                              want[127:64], rsp_tdata[63:0], want[63:0], rsp_tdata[127:64]);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import aes_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CsrKeyHigh;
   logic [63:0] csr_wdata = '0;
   int error_count, cipher_pending;
   int send_idle_pct, recv_idle_pct;
   bit hold_off = 1'b0;

   always #1 clock = ~clock;

   aes128_block_encrypt_core u_top (.*);
   aes_encrypt_checker u_chk (.*);

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // tvalid stays high after the handshake; an idle cycle or the caller drops it
   task automatic send_item(input logic [63:0] hi, input logic [63:0] lo);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lo, hi};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
      req_tvalid <= 1'b0;
      while (cipher_pending != 0) @(negedge clock);
      repeat (15) @(negedge clock);
      csr_we <= 1'b1; csr_index <= CsrKeyHigh; csr_wdata <= hi;
      @(negedge clock);
      csr_index <= CsrKeyLow; csr_wdata <= lo;
      @(negedge clock);
      // out-of-range index is ignored
      csr_index <= 2'd3; csr_wdata <= $urandom();
      @(negedge clock);
      csr_we <= 1'b0;
      repeat (15) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64(input int mode);
      case (mode)
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(63);
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   initial begin
      send_idle_pct = 35;
      recv_idle_pct = 52;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // zero key before any write
      send_item('0, '0);
      send_item('1, '1);
      write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_item(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_item(64'h8000000000000000, 64'h0000000000000001);
      send_item(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      send_item(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      write_key('1, '1);
      send_item('0, '0);
      send_item('1, '1);
      // long receiver stall while the sender keeps pushing
      hold_off = 1'b1;
      fork
         repeat (60) send_item(rand64(3), rand64(3));
         begin
            repeat (80) @(negedge clock);
            hold_off = 1'b0;
         end
      join
      for (int p = 0; p < 3; p++) begin
         if (p == 1) begin send_idle_pct = 52; recv_idle_pct = 35; end
         if (p == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         write_key(rand64($urandom_range(3)), rand64($urandom_range(3)));
         repeat (160)
            send_item(rand64($urandom_range(3) | 2), rand64($urandom_range(3) | 2));
      end
      write_key('0, '1);
      repeat (10) send_item(rand64(3), rand64(3));
      req_tvalid <= 1'b0;
      while (cipher_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
